// File: rtl/stcl_pkg.sv
// ----------------------------------------------------------------------------
// stcl_pkg
// shared types, constants and command codes of the stripe component labeler
// ----------------------------------------------------------------------------
`default_nettype none

package stcl_pkg;

  // default image limits
  localparam int unsigned MAX_WIDTH_DEF  = 128;
  localparam int unsigned MAX_HEIGHT_DEF = 128;

  // field widths
  localparam int unsigned PIXEL_W = 8;
  localparam int unsigned INDEX_W = 14;
  localparam int unsigned VALUE_W = 13;
  localparam int unsigned LABEL_W = 16;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned S_DATA_W = 24;
  localparam int unsigned M_DATA_W = 16;

  localparam logic [CFG_W-1:0] DIM_RESET = 8'd128;

  // register indexes
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // input command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // result kinds
  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_LABEL = 1'b1;

  // neighbor walk order
  typedef enum logic [2:0] {
    NB_LEFT    = 3'd0,
    NB_UPLEFT  = 3'd1,
    NB_UP      = 3'd2,
    NB_UPRIGHT = 3'd3,
    NB_END     = 3'd4
  } nb_e;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ,
    OP_RD_OUT,
    OP_PIX_RD,
    OP_PIX_ROOT,
    OP_NB_RD,
    OP_NB_SKIP,
    OP_FIND_A,
    OP_FIND_STEP1,
    OP_FIND_STEP2,
    OP_FIND_NEXT,
    OP_LINK,
    OP_PAR_RD,
    OP_NEW_LABEL,
    OP_COPY_RD
  } dp_op_e;

  // copy write, finish and advance are flags beside the operation code
  typedef struct packed {
    dp_op_e op;
    logic   copy_wr;
    logic   finish;
    logic   advance;
  } dp_cmd_t;

  typedef struct packed {
    logic load_last;
    logic out_free;
    logic pix_fg;
    logic nb_done;
    logic nb_valid;
    logic find_root;
    logic find_second;
    logic par_self;
    logic cur_last;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/stcl_ram.sv
// ----------------------------------------------------------------------------
// stcl_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module stcl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/stcl_ctrl.sv
// ----------------------------------------------------------------------------
// stcl_ctrl
// sequencer for load, read, union pass and relabel pass
// ----------------------------------------------------------------------------
`default_nettype none

module stcl_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_valid_i,
  input  wire logic                command_i,
  output logic                     s_ready_o,
  input  wire stcl_pkg::dp_status_t st_i,
  output stcl_pkg::dp_cmd_t        cmd_o
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_READ     = 14'b00000000000010,
    S_P1_RD    = 14'b00000000000100,
    S_P1_CK    = 14'b00000000001000,
    S_NB_SEL   = 14'b00000000010000,
    S_NB_CK    = 14'b00000000100000,
    S_FIND_CK1 = 14'b00000001000000,
    S_FIND_CK2 = 14'b00000010000000,
    S_P2_RD    = 14'b00000100000000,
    S_P2_CK    = 14'b00001000000000,
    S_P2_PCK   = 14'b00010000000000,
    S_P2_LCK   = 14'b00100000000000,
    S_DONE     = 14'b01000000000000,
    S_SPARE    = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.op      = stcl_pkg::OP_NONE;
    s_ready_o     = (state_q == S_IDLE) && st_i.out_free;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i && s_ready_o) begin
          if (command_i == stcl_pkg::CMD_READ) begin
            cmd_o.op = stcl_pkg::OP_READ;
            state_d  = S_READ;
          end else begin
            cmd_o.op = stcl_pkg::OP_LOAD;
            if (st_i.load_last) state_d = S_P1_RD;
          end
        end
      end
      S_READ: begin
        cmd_o.op = stcl_pkg::OP_RD_OUT;
        state_d  = S_IDLE;
      end
      S_P1_RD: begin
        cmd_o.op = stcl_pkg::OP_PIX_RD;
        state_d  = S_P1_CK;
      end
      S_P1_CK: begin
        if (st_i.pix_fg) begin
          cmd_o.op = stcl_pkg::OP_PIX_ROOT;
          state_d  = S_NB_SEL;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = st_i.cur_last ? S_P2_RD : S_P1_RD;
        end
      end
      S_NB_SEL: begin
        if (st_i.nb_done) begin
          cmd_o.advance = 1'b1;
          state_d       = st_i.cur_last ? S_P2_RD : S_P1_RD;
        end else if (st_i.nb_valid) begin
          cmd_o.op = stcl_pkg::OP_NB_RD;
          state_d  = S_NB_CK;
        end else begin
          cmd_o.op = stcl_pkg::OP_NB_SKIP;
        end
      end
      S_NB_CK: begin
        if (st_i.pix_fg) begin
          cmd_o.op = stcl_pkg::OP_FIND_A;
          state_d  = S_FIND_CK1;
        end else begin
          cmd_o.op = stcl_pkg::OP_NB_SKIP;
          state_d  = S_NB_SEL;
        end
      end
      S_FIND_CK1: begin
        if (st_i.find_root) begin
          if (st_i.find_second) begin
            cmd_o.op = stcl_pkg::OP_LINK;
            state_d  = S_NB_SEL;
          end else begin
            cmd_o.op = stcl_pkg::OP_FIND_NEXT;
          end
        end else begin
          cmd_o.op = stcl_pkg::OP_FIND_STEP1;
          state_d  = S_FIND_CK2;
        end
      end
      S_FIND_CK2: begin
        cmd_o.op = stcl_pkg::OP_FIND_STEP2;
        state_d  = S_FIND_CK1;
      end
      S_P2_RD: begin
        cmd_o.op = stcl_pkg::OP_PIX_RD;
        state_d  = S_P2_CK;
      end
      S_P2_CK: begin
        if (st_i.pix_fg) begin
          cmd_o.op = stcl_pkg::OP_PAR_RD;
          state_d  = S_P2_PCK;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = st_i.cur_last ? S_DONE : S_P2_RD;
        end
      end
      S_P2_PCK: begin
        if (st_i.par_self) begin
          cmd_o.op      = stcl_pkg::OP_NEW_LABEL;
          cmd_o.advance = 1'b1;
          state_d       = st_i.cur_last ? S_DONE : S_P2_RD;
        end else begin
          cmd_o.op = stcl_pkg::OP_COPY_RD;
          state_d  = S_P2_LCK;
        end
      end
      S_P2_LCK: begin
        cmd_o.copy_wr = 1'b1;
        cmd_o.advance = 1'b1;
        state_d       = st_i.cur_last ? S_DONE : S_P2_RD;
      end
      S_DONE: begin
        if (st_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/stcl_dp.sv
// ----------------------------------------------------------------------------
// stcl_dp
// label and parent memories, scan counters, union-find registers, result slot
// ----------------------------------------------------------------------------
`default_nettype none

module stcl_dp #(
  parameter int unsigned MAX_WIDTH  = stcl_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = stcl_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [stcl_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  wire logic [stcl_pkg::PIXEL_W-1:0]  pixel_i,
  input  wire logic [stcl_pkg::INDEX_W-1:0]  index_i,
  input  wire stcl_pkg::dp_cmd_t             cmd_i,
  output stcl_pkg::dp_status_t               st_o,
  input  wire logic                          m_ready_i,
  output logic                               m_valid_o,
  output logic                               m_kind_o,
  output logic [stcl_pkg::VALUE_W-1:0]       m_value_o
);

  localparam int unsigned AREA = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW   = $clog2(AREA);
  localparam int unsigned PW   = $clog2(AREA + 1);
  localparam int unsigned WDW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HDW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned WCW  = $clog2(MAX_WIDTH);
  localparam int unsigned HCW  = $clog2(MAX_HEIGHT);
  localparam int unsigned LW   = stcl_pkg::LABEL_W;

  // configuration
  logic [stcl_pkg::CFG_W-1:0] cfg_w_q, cfg_h_q;
  logic [WDW-1:0]             w_eff;
  logic [HDW-1:0]             h_eff;
  logic [PW-1:0]              area;

  // scan and union-find registers
  logic [AW-1:0]  pos_q, cur_q, x_q, ra_q;
  logic [WCW-1:0] col_q;
  logic [HCW-1:0] row_q;
  stcl_pkg::nb_e  nb_q;
  logic           second_q;
  logic [LW-1:0]  n_q;
  logic [PW-1:0]  larea_q;
  logic           ready_q, rd_ok_q;

  // result slot
  logic                         out_valid_q, out_kind_q;
  logic [stcl_pkg::VALUE_W-1:0] out_value_q;

  // memory ports
  logic          lab_we, lab_re, par_we, par_re;
  logic [AW-1:0] lab_waddr, lab_raddr, par_waddr, par_raddr;
  logic [LW-1:0] lab_wdata, lab_rdata;
  logic [AW-1:0] par_wdata, par_rdata;

  logic [AW-1:0] w_ext, nb_addr;
  logic          nb_valid, col_first, row_first, col_lastc, out_free;

  always_comb begin
    if (cfg_w_q < 8'd2) w_eff = WDW'(2);
    else if (32'(cfg_w_q) > MAX_WIDTH) w_eff = WDW'(MAX_WIDTH);
    else w_eff = WDW'(cfg_w_q);
    if (cfg_h_q < 8'd2) h_eff = HDW'(2);
    else if (32'(cfg_h_q) > MAX_HEIGHT) h_eff = HDW'(MAX_HEIGHT);
    else h_eff = HDW'(cfg_h_q);
  end

  assign area = PW'(w_eff) * PW'(h_eff);
  assign w_ext = AW'(w_eff);

  assign col_first = (col_q == '0);
  assign row_first = (row_q == '0);
  assign col_lastc = ((32'(col_q) + 32'd1) == 32'(w_eff));

  // neighbor address and presence for the current walk step
  always_comb begin
    nb_addr  = cur_q;
    nb_valid = 1'b0;
    case (nb_q)
      stcl_pkg::NB_LEFT: begin
        nb_addr  = cur_q - AW'(1);
        nb_valid = !col_first;
      end
      stcl_pkg::NB_UPLEFT: begin
        nb_addr  = cur_q - w_ext - AW'(1);
        nb_valid = !col_first && !row_first;
      end
      stcl_pkg::NB_UP: begin
        nb_addr  = cur_q - w_ext;
        nb_valid = !row_first;
      end
      stcl_pkg::NB_UPRIGHT: begin
        nb_addr  = cur_q - w_ext + AW'(1);
        nb_valid = !row_first && !col_lastc;
      end
      default: begin
        nb_addr  = cur_q;
        nb_valid = 1'b0;
      end
    endcase
  end

  assign out_free = !out_valid_q || m_ready_i;

  always_comb begin
    st_o.load_last   = (32'(pos_q) + 32'd1) >= 32'(area);
    st_o.out_free    = out_free;
    st_o.pix_fg      = (lab_rdata != '0);
    st_o.nb_done     = (nb_q == stcl_pkg::NB_END);
    st_o.nb_valid    = nb_valid;
    st_o.find_root   = (par_rdata == x_q);
    st_o.find_second = second_q;
    st_o.par_self    = (par_rdata == cur_q);
    st_o.cur_last    = (32'(cur_q) + 32'd1) == 32'(area);
  end

  // memory port steering
  always_comb begin
    lab_we    = 1'b0;
    lab_waddr = cur_q;
    lab_wdata = lab_rdata;
    lab_re    = 1'b0;
    lab_raddr = cur_q;
    par_we    = 1'b0;
    par_waddr = cur_q;
    par_wdata = cur_q;
    par_re    = 1'b0;
    par_raddr = cur_q;
    case (cmd_i.op)
      stcl_pkg::OP_LOAD: begin
        lab_we    = 32'(pos_q) < 32'(area);
        lab_waddr = pos_q;
        lab_wdata = LW'(pixel_i != '0);
      end
      stcl_pkg::OP_READ: begin
        lab_re    = 1'b1;
        lab_raddr = AW'(index_i);
      end
      stcl_pkg::OP_PIX_RD: lab_re = 1'b1;
      stcl_pkg::OP_PIX_ROOT: par_we = 1'b1;
      stcl_pkg::OP_NB_RD: begin
        lab_re    = 1'b1;
        lab_raddr = nb_addr;
      end
      stcl_pkg::OP_FIND_A: par_re = 1'b1;
      stcl_pkg::OP_FIND_STEP1: begin
        par_re    = 1'b1;
        par_raddr = par_rdata;
      end
      stcl_pkg::OP_FIND_STEP2: begin
        // path halving: skip one level, then continue from the grandparent
        par_we    = 1'b1;
        par_waddr = x_q;
        par_wdata = par_rdata;
        par_re    = 1'b1;
        par_raddr = par_rdata;
      end
      stcl_pkg::OP_FIND_NEXT: begin
        par_re    = 1'b1;
        par_raddr = nb_addr;
      end
      stcl_pkg::OP_LINK: begin
        // smaller root wins, so each root is its component's first pixel
        par_we    = (ra_q != x_q);
        par_waddr = (ra_q < x_q) ? x_q : ra_q;
        par_wdata = (ra_q < x_q) ? ra_q : x_q;
      end
      stcl_pkg::OP_PAR_RD: par_re = 1'b1;
      stcl_pkg::OP_NEW_LABEL: begin
        lab_we    = 1'b1;
        lab_wdata = n_q + LW'(1);
      end
      stcl_pkg::OP_COPY_RD: begin
        lab_re    = 1'b1;
        lab_raddr = par_rdata;
      end
      default: ;
    endcase
    if (cmd_i.copy_wr) begin
      lab_we    = 1'b1;
      lab_waddr = cur_q;
      lab_wdata = lab_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q     <= stcl_pkg::DIM_RESET;
      cfg_h_q     <= stcl_pkg::DIM_RESET;
      pos_q       <= '0;
      cur_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      nb_q        <= stcl_pkg::NB_LEFT;
      second_q    <= 1'b0;
      n_q         <= '0;
      larea_q     <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (stcl_pkg::cfg_reg_e'(cfg_idx_i))
          stcl_pkg::REG_IMAGE_WIDTH:  cfg_w_q <= cfg_wdata_i;
          stcl_pkg::REG_IMAGE_HEIGHT: cfg_h_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (m_ready_i) out_valid_q <= 1'b0;

      case (cmd_i.op)
        stcl_pkg::OP_LOAD: begin
          if (pos_q == '0) ready_q <= 1'b0;
          if (st_o.load_last) begin
            pos_q <= '0;
            cur_q <= '0;
            col_q <= '0;
            row_q <= '0;
            n_q   <= '0;
          end else begin
            pos_q <= pos_q + AW'(1);
          end
        end
        stcl_pkg::OP_RD_OUT: out_valid_q <= 1'b1;
        stcl_pkg::OP_PIX_ROOT: nb_q <= stcl_pkg::NB_LEFT;
        stcl_pkg::OP_NB_SKIP, stcl_pkg::OP_LINK: nb_q <= stcl_pkg::nb_e'(nb_q + 3'd1);
        stcl_pkg::OP_FIND_A: second_q <= 1'b0;
        stcl_pkg::OP_FIND_NEXT: second_q <= 1'b1;
        stcl_pkg::OP_NEW_LABEL: n_q <= n_q + LW'(1);
        default: ;
      endcase

      if (cmd_i.advance) begin
        if (st_o.cur_last) begin
          cur_q <= '0;
          col_q <= '0;
          row_q <= '0;
        end else begin
          cur_q <= cur_q + AW'(1);
          if (col_lastc) begin
            col_q <= '0;
            row_q <= row_q + HCW'(1);
          end else begin
            col_q <= col_q + WCW'(1);
          end
        end
      end

      if (cmd_i.finish) begin
        larea_q     <= area;
        ready_q     <= 1'b1;
        out_valid_q <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      stcl_pkg::OP_READ: begin
        rd_ok_q <= ready_q && (32'(index_i) < 32'(larea_q)) && (32'(index_i) < AREA);
      end
      stcl_pkg::OP_RD_OUT: begin
        out_kind_q  <= stcl_pkg::KIND_LABEL;
        out_value_q <= rd_ok_q ? lab_rdata[stcl_pkg::VALUE_W-1:0] : '0;
      end
      stcl_pkg::OP_FIND_A: x_q <= cur_q;
      stcl_pkg::OP_FIND_STEP2: x_q <= par_rdata;
      stcl_pkg::OP_FIND_NEXT: begin
        ra_q <= x_q;
        x_q  <= nb_addr;
      end
      default: ;
    endcase
    if (cmd_i.finish) begin
      out_kind_q  <= stcl_pkg::KIND_COUNT;
      out_value_q <= stcl_pkg::VALUE_W'(n_q + LW'(1));
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_kind_o  = out_kind_q;
  assign m_value_o = out_value_q;

  stcl_ram #(.WIDTH(LW), .DEPTH(AREA)) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (lab_we),
    .waddr_i (lab_waddr),
    .wdata_i (lab_wdata),
    .re_i    (lab_re),
    .raddr_i (lab_raddr),
    .rdata_o (lab_rdata)
  );

  stcl_ram #(.WIDTH(AW), .DEPTH(AREA)) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (par_waddr),
    .wdata_i (par_wdata),
    .re_i    (par_re),
    .raddr_i (par_raddr),
    .rdata_o (par_rdata)
  );

`ifndef SYNTHESIS
  // a result is only pushed into a slot that is empty or draining
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish || cmd_i.op == stcl_pkg::OP_RD_OUT) |-> out_free)
    else $error("result pushed into a full slot");

  // labels become valid only at the end of the relabel pass
  a_ready_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ready_q) |-> $past(cmd_i.finish))
    else $error("image marked ready outside finish");

  // halving write never lands on the address read in the same cycle
  a_halve_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == stcl_pkg::OP_FIND_STEP2) |-> (par_rdata != x_q))
    else $error("parent write collides with parent read");

  // load position stays inside the store
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) < AREA)
    else $error("load position beyond store");
`endif

endmodule

`default_nettype wire

// File: rtl/stripe_component_labeler_top.sv
// ----------------------------------------------------------------------------
// stripe_component_labeler_top
// 8-connected component labeler over a raster-loaded binary image
// ----------------------------------------------------------------------------
//
// channel   dir  handshake              tdata / tuser
// s         in   s_tvalid_i/s_tready_o  tdata: pixel_value[7:0], read_index[21:8]
//                                       tuser: command
// m         out  m_tvalid_o/m_tready_i  tdata: value[12:0]; tuser: result_kind
// cfg       in   cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// flow: a read word reads the label ram before its result goes out.
// union pass: a foreground pixel becomes a root, then each neighbor slot
// inside the image is read and a foreground one is joined by find with
// path halving; relabel pass: a root gets a new label, any other foreground
// pixel copies its root's label; every memory read is registered.
// reset: control state clears at once, the memories need no clearing pass.
// stalls: the result slot holds one word; input is refused while it is full
// and not draining, during a read, or while labeling runs.
// ----------------------------------------------------------------------------
`default_nettype none

module stripe_component_labeler_top #(
  parameter int unsigned MAX_WIDTH  = stcl_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = stcl_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_idx_i,
  input  wire logic [stcl_pkg::CFG_W-1:0]     cfg_wdata_i,
  // input words
  input  wire logic                           s_tvalid_i,
  output logic                                s_tready_o,
  input  wire logic [stcl_pkg::S_DATA_W-1:0]  s_tdata_i,  // pixel_value, read_index
  input  wire logic                           s_tuser_i,  // command
  // result words
  output logic                                m_tvalid_o,
  input  wire logic                           m_tready_i,
  output logic      [stcl_pkg::M_DATA_W-1:0]  m_tdata_o,  // value
  output logic                                m_tuser_o   // result_kind
);

  stcl_pkg::dp_cmd_t    cmd;
  stcl_pkg::dp_status_t st;
  logic [stcl_pkg::VALUE_W-1:0] m_value;

  // controller sequences the passes
  stcl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_tvalid_i),
    .command_i (s_tuser_i),
    .s_ready_o (s_tready_o),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  // datapath holds memories, counters and the result slot
  stcl_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pixel_i     (s_tdata_i[stcl_pkg::PIXEL_W-1:0]),
    .index_i     (s_tdata_i[stcl_pkg::PIXEL_W +: stcl_pkg::INDEX_W]),
    .cmd_i       (cmd),
    .st_o        (st),
    .m_ready_i   (m_tready_i),
    .m_valid_o   (m_tvalid_o),
    .m_kind_o    (m_tuser_o),
    .m_value_o   (m_value)
  );

  // zero pad to whole bytes
  assign m_tdata_o = stcl_pkg::M_DATA_W'(m_value);

endmodule

`default_nettype wire

// File: tb/stripe_component_labeler_top_test.sv
// ----------------------------------------------------------------------------
// stripe_component_labeler_top_test
// self-checking test of the 8-connected component labeler
// ----------------------------------------------------------------------------
// An internal labeler model predicts every result word. The label counts and
// the labels read back are checked in order against what the block returns.
// The test covers directed corner cases and then random images of many
// sizes, with random idle gaps on the input and the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module stripe_component_labeler_top_test;
  import stcl_pkg::*;

  localparam int unsigned AREA_CAP    = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int unsigned ITEM_GOAL   = 1950;
  localparam int unsigned STALL_LIMIT = 200000;
  localparam int unsigned SETTLE      = 24;

  typedef struct packed {
    logic                kind;
    logic [VALUE_W-1:0]  value;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic s_tvalid_i = 1'b0;
  logic s_tready_o;
  logic [S_DATA_W-1:0] s_tdata_i = '0;  // pixel_value[7:0], read_index[21:8]
  logic s_tuser_i = 1'b0;               // command
  logic m_tvalid_o;
  logic m_tready_i = 1'b0;
  logic [M_DATA_W-1:0] m_tdata_o;       // value[12:0]
  logic m_tuser_o;                      // result_kind

  stripe_component_labeler_top i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_tvalid_i, .s_tready_o, .s_tdata_i, .s_tuser_i,
    .m_tvalid_o, .m_tready_i, .m_tdata_o, .m_tuser_o
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // labeler model state
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]   mdl_width  = DIM_RESET;
  logic [CFG_W-1:0]   mdl_height = DIM_RESET;
  logic [LABEL_W-1:0] pix_store [AREA_CAP];
  int unsigned        uf_parent [AREA_CAP];
  int unsigned        load_pos = 0;
  logic [VALUE_W-1:0] label_count = '0;
  logic               labels_valid = 1'b0;
  int unsigned        labeled_px = 0;

  result_t     pending_results [$];
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned mismatches = 0;
  int unsigned images_done = 0;
  int unsigned reads_done = 0;

  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  // find with path halving, as the block's union-find does
  function automatic int unsigned find_root(int unsigned i);
    while (uf_parent[i] != i) begin
      uf_parent[i] = uf_parent[uf_parent[i]];
      i = uf_parent[i];
    end
    return i;
  endfunction

  function automatic void unite(int unsigned a, int unsigned b);
    int unsigned ra, rb;
    ra = find_root(a);
    rb = find_root(b);
    if (ra < rb) uf_parent[rb] = ra;
    else if (rb < ra) uf_parent[ra] = rb;
  endfunction

  // label the stored image: union pass, then number roots in raster order
  function automatic void label_image(int unsigned w, int unsigned h);
    int unsigned i, up, rt, n;
    n = 0;
    for (int unsigned r = 0; r < h; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        i = r * w + c;
        if (pix_store[i] != 0) begin
          uf_parent[i] = i;
          if (c > 0 && pix_store[i-1] != 0) unite(i, i - 1);
          if (r > 0) begin
            up = i - w;
            if (c > 0 && pix_store[up-1] != 0) unite(i, up - 1);
            if (pix_store[up] != 0) unite(i, up);
            if (c + 1 < w && pix_store[up+1] != 0) unite(i, up + 1);
          end
        end
      end
    end
    for (i = 0; i < w * h; i++) begin
      if (pix_store[i] != 0) begin
        rt = find_root(i);
        if (rt == i) begin
          n++;
          pix_store[i] = LABEL_W'(n);
        end else begin
          pix_store[i] = pix_store[rt];
        end
      end
    end
    label_count = VALUE_W'(n + 1);
    labeled_px = w * h;
    labels_valid = 1'b1;
  endfunction

  // model of one accepted input word; pushes the result it causes, if any
  function automatic void predict_word(logic cmd, logic [PIXEL_W-1:0] pix,
                                       logic [INDEX_W-1:0] idx);
    int unsigned w, h, area;
    result_t res;
    w = clamp_dim(mdl_width, MAX_WIDTH_DEF);
    h = clamp_dim(mdl_height, MAX_HEIGHT_DEF);
    area = w * h;
    if (cmd == CMD_LOAD) begin
      if (load_pos == 0) labels_valid = 1'b0;
      if (load_pos < area) pix_store[load_pos] = (pix != 0) ? 1 : 0;
      load_pos++;
      if (load_pos >= area) begin
        label_image(w, h);
        load_pos = 0;
        res.kind = KIND_COUNT;
        res.value = label_count;
        pending_results.push_back(res);
        images_done++;
      end
    end else begin
      res.kind = KIND_LABEL;
      res.value = '0;
      if (labels_valid && idx < labeled_px) res.value = pix_store[idx][VALUE_W-1:0];
      pending_results.push_back(res);
      reads_done++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(logic cmd, logic [PIXEL_W-1:0] pix, logic [INDEX_W-1:0] idx);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= cmd;
    s_tdata_i  <= {idx, pix};
    do @(posedge clk_i); while (!s_tready_o);
    predict_word(cmd, pix, idx);
    words_in++;
  endtask

  task automatic load_pixel(logic fg);
    logic [PIXEL_W-1:0] pix;
    pix = fg ? PIXEL_W'($urandom_range(1, 255)) : '0;
    send_word(CMD_LOAD, pix, INDEX_W'($urandom()));
  endtask

  task automatic read_label(logic [INDEX_W-1:0] idx);
    send_word(CMD_READ, PIXEL_W'($urandom()), idx);
  endtask

  // hold off input until every expected word is back, then let the block settle
  task automatic drain();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == REG_IMAGE_WIDTH) mdl_width = data;
    else mdl_height = data;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    drain();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  // loads the rest of the current image, foreground with the given percentage
  task automatic load_image(int unsigned density, bit noisy);
    int unsigned area;
    area = clamp_dim(mdl_width, MAX_WIDTH_DEF) * clamp_dim(mdl_height, MAX_HEIGHT_DEF);
    while (load_pos < area) begin
      // stray reads while loading; after the image's first pixel they must return label 0
      if (noisy && $urandom_range(0, 9) == 0) read_label(INDEX_W'($urandom()));
      load_pixel($urandom_range(0, 99) < density);
      if (load_pos == 0) break;
    end
  endtask

  task automatic read_some(int unsigned n);
    logic [INDEX_W-1:0] idx;
    repeat (n) begin
      if (labeled_px != 0 && $urandom_range(0, 9) < 8) idx = INDEX_W'($urandom_range(0, labeled_px - 1));
      else idx = INDEX_W'($urandom());
      read_label(idx);
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------
  task automatic test_read_before_labeling();
    read_label('0);
    read_label('1);
  endtask

  task automatic test_diagonal_joins();
    // 3x2: corners touch only diagonally, still one component
    set_size(8'd3, 8'd2);
    load_pixel(1'b1); load_pixel(1'b0); load_pixel(1'b1);
    load_pixel(1'b0); load_pixel(1'b1); load_pixel(1'b0);
    for (int unsigned i = 0; i < 6; i++) read_label(INDEX_W'(i));
    read_label(INDEX_W'(6));         // past the labeled image
    read_label(INDEX_W'(16383));
  endtask

  task automatic test_out_of_range_dims();
    // width 0 and height 1 both saturate to 2
    set_size(8'd0, 8'd1);
    load_pixel(1'b1); load_pixel(1'b0); load_pixel(1'b0); load_pixel(1'b1);
    read_label(INDEX_W'(3));
    // a fresh load hides the old labels until the next labeling
    load_pixel(1'b1);
    read_label(INDEX_W'(0));
  endtask

  task automatic test_shrink_mid_load();
    // finish the pending image, then part-load a 4x4 one and shrink it
    set_size(8'd2, 8'd2);
    load_image(50, 1'b0);
    set_size(8'd4, 8'd4);
    repeat (6) load_pixel($urandom_range(0, 1));
    set_size(8'd2, 8'd2);
    load_pixel(1'b1);                // stores nothing, labels at once
    read_some(3);
  endtask

  task automatic test_widest_and_tallest();
    set_size(8'd255, 8'd2);          // width saturates to the maximum
    load_image(40, 1'b0);
    read_some(4);
    set_size(8'd2, 8'd128);
    load_image(60, 1'b0);
    read_some(4);
    set_size(8'd128, 8'd3);
    load_image(100, 1'b0);           // all foreground: one component
    read_some(2);
  endtask

  // ---------------------------------------------------------------------------
  // random images: mostly small complete images, some broken sequences
  // ---------------------------------------------------------------------------
  task automatic test_random_images();
    logic [CFG_W-1:0] w, h;
    int unsigned pick;
    while (words_in < ITEM_GOAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        w = CFG_W'($urandom_range(2, 9));
        h = CFG_W'($urandom_range(2, 9));
      end else if (pick < 93) begin
        w = CFG_W'($urandom_range(0, 255));
        h = CFG_W'($urandom_range(0, 3));
      end else begin
        w = CFG_W'($urandom_range(0, 3));
        h = CFG_W'($urandom_range(0, 255));
      end
      set_size(w, h);
      if ($urandom_range(0, 9) == 0) begin
        // abandon the image part way and change size before finishing it
        repeat ($urandom_range(1, 20)) load_pixel($urandom_range(0, 1));
        set_size(CFG_W'($urandom_range(2, 6)), CFG_W'($urandom_range(2, 6)));
      end
      load_image($urandom_range(0, 100), $urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) drain();
      read_some($urandom_range(2, 12));
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure and in-order checking
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      m_tready_i <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      m_tready_i <= 1'b0;
      repeat (gap_len() + 1) @(posedge clk_i);
    end
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    $display("mismatch on %s at result word %0d: got %0d, expected %0d",
             what, words_out, got, want);
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", m_tdata_o, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser_o !== want.kind) report_mismatch("result_kind", m_tuser_o, want.kind);
        if (m_tdata_o !== M_DATA_W'(want.value)) report_mismatch("value", m_tdata_o, want.value);
      end
      words_out++;
    end
  end

  // watchdog: ends the run when nothing moves for too long
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_read_before_labeling();
    test_diagonal_joins();
    test_out_of_range_dims();
    test_shrink_mid_load();
    test_widest_and_tallest();
    test_random_images();
    drain();
    if (pending_results.size() != 0) begin
      mismatches++;
      $display("%0d expected words never arrived", pending_results.size());
    end
    $display("covered %0d input words, %0d labeled images, %0d label reads",
             words_in, images_done, reads_done);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
rtl/stcl_pkg.sv
rtl/stcl_ram.sv
rtl/stcl_ctrl.sv
rtl/stcl_dp.sv
rtl/stripe_component_labeler_top.sv
tb/stripe_component_labeler_top_test.sv
